FILE: src/sql_token_lexer_unit_assert.svh
// Assertion macros used by the lexer checker.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef SQL_TOKEN_LEXER_UNIT_ASSERT_SVH
`define SQL_TOKEN_LEXER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SQLLEX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SQLLEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sqllex_pkg.sv
package sqllex_pkg;

  // Lexer modes between bytes.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_BANG   = 3'd4,
    MODE_GT     = 3'd5,
    MODE_LT     = 3'd6,
    MODE_STOP   = 3'd7
  } lex_mode_e;

  // Token kinds as they appear on the result channel.
  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_IDENT   = 5'd1;
  localparam logic [4:0] TK_NUMBER  = 5'd2;
  localparam logic [4:0] TK_STRING  = 5'd3;
  localparam logic [4:0] TK_SELECT  = 5'd4;
  localparam logic [4:0] TK_STAR    = 5'd14;
  localparam logic [4:0] TK_COMMA   = 5'd15;
  localparam logic [4:0] TK_SEMI    = 5'd16;
  localparam logic [4:0] TK_LPAREN  = 5'd17;
  localparam logic [4:0] TK_RPAREN  = 5'd18;
  localparam logic [4:0] TK_EQ      = 5'd19;
  localparam logic [4:0] TK_NE      = 5'd20;
  localparam logic [4:0] TK_GT      = 5'd21;
  localparam logic [4:0] TK_GE      = 5'd22;
  localparam logic [4:0] TK_LT      = 5'd23;
  localparam logic [4:0] TK_LE      = 5'd24;
  localparam logic [4:0] TK_INVALID = 5'd25;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Number of identifier bytes kept for keyword matching.
  localparam int unsigned KW_DEPTH = 7;
  localparam int unsigned KW_COUNT = 10;

  // Keyword text, first character in the top byte, zero padded to seven bytes.
  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    {"SELECT", 8'h00}, {"FROM", 24'h0}, {"WHERE", 16'h0}, {"INSERT", 8'h00},
    {"INTO", 24'h0}, {"VALUES", 8'h00}, {"CREATE", 8'h00}, {"TABLE", 16'h0},
    {"INT", 32'h0}, "VARCHAR"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd5, 3'd3, 3'd7
  };

  // One result item as it sits in the output queue.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } result_t;

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
  endfunction

  // Kind of an identifier of at most seven bytes; chars beyond len are zero.
  function automatic logic [4:0] kw_lookup(input logic [55:0] chars,
                                           input logic [2:0] len);
    logic [4:0] kind;
    kind = TK_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len == KW_LEN[k] && chars == KW_TEXT[k]) begin
        kind = TK_SELECT + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

FILE: src/sql_token_lexer_unit.sv
// A result is written to the result queue by the transfer that causes it and is offered from there.
// Throughput: one input transfer per cycle while the result queue has room and each byte
// yields at most one token; a byte that both ends a token and starts one yields two, and
// the single result port then limits the sustained rate.
// Reset (rst_ni, asynchronous, active low) empties the result queue and returns
// the lexer to idle at offset zero.
module sql_token_lexer_unit #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  // Token channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] text_start_o,
  output logic [15:0] text_length_o,
  output logic        last_of_run_o
);

  localparam logic [POSITION_BITS-1:0] PosMax  = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] KwLimit = POSITION_BITS'(sqllex_pkg::KW_DEPTH);
  localparam logic [POSITION_BITS-1:0] KwSpan  = POSITION_BITS'(8);

  // Saturating increment used for offsets and lengths.
  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  // Offsets and lengths leave the block as 16-bit fields.
  function automatic logic [15:0] to_field(input logic [POSITION_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Lexer state.
  // ---------------------------------------------------------------------------
  sqllex_pkg::lex_mode_e     mode_q, mode_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d;
  logic [POSITION_BITS-1:0]  start_q, start_d;
  logic [POSITION_BITS-1:0]  len_q, len_d;
  logic [7:0]                kw_q [sqllex_pkg::KW_DEPTH];
  logic [7:0]                kw_d [sqllex_pkg::KW_DEPTH];

  // Result queue: four entries, so a transfer that yields two tokens always fits
  // whenever at most two entries are occupied.
  sqllex_pkg::result_t fifo_q [4];
  logic [1:0]          wr_q, rd_q;
  logic [2:0]          cnt_q, cnt_d;

  logic accept;
  logic pop;
  assign in_stall_o  = (cnt_q > 3'd2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && !out_stall_i;

  // ---------------------------------------------------------------------------
  // Byte classification.
  // ---------------------------------------------------------------------------
  logic [7:0] ch;
  logic       is_alpha, is_digit, is_space, is_quote, is_nul, is_eq, ident_cont;
  logic [7:0] ch_upper;

  assign ch         = data_byte_i;
  assign is_alpha   = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  assign is_digit   = (ch >= 8'h30 && ch <= 8'h39);
  assign is_space   = (ch == sqllex_pkg::CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D);
  assign is_quote   = (ch == sqllex_pkg::CH_QUOTE);
  assign is_nul     = (ch == sqllex_pkg::CH_NUL);
  assign is_eq      = (ch == sqllex_pkg::CH_EQ);
  assign ident_cont = is_alpha || is_digit || (ch == sqllex_pkg::CH_US);
  assign ch_upper   = sqllex_pkg::to_upper(ch);

  // Restart means the byte is lexed from idle: either the lexer already sits
  // idle, or the byte ends the pending token.
  logic is_op_mode;
  logic restart;
  assign is_op_mode = (mode_q == sqllex_pkg::MODE_BANG) || (mode_q == sqllex_pkg::MODE_GT) ||
                      (mode_q == sqllex_pkg::MODE_LT);
  assign restart = !end_of_input_i &&
                   ((mode_q == sqllex_pkg::MODE_IDLE) ||
                    ((mode_q == sqllex_pkg::MODE_IDENT) && !ident_cont) ||
                    ((mode_q == sqllex_pkg::MODE_NUMBER) && !is_digit) ||
                    (is_op_mode && !is_eq));

  // ---------------------------------------------------------------------------
  // What a byte does when lexed from idle.
  // ---------------------------------------------------------------------------
  sqllex_pkg::lex_mode_e idle_mode;
  logic                  idle_emit;
  logic [4:0]            idle_kind;

  always_comb begin
    idle_mode = sqllex_pkg::MODE_IDLE;
    idle_emit = 1'b0;
    idle_kind = sqllex_pkg::TK_INVALID;
    if (is_space) begin
      idle_mode = sqllex_pkg::MODE_IDLE;
    end else if (is_nul) begin
      idle_mode = sqllex_pkg::MODE_STOP;
    end else if (is_alpha) begin
      idle_mode = sqllex_pkg::MODE_IDENT;
    end else if (is_digit) begin
      idle_mode = sqllex_pkg::MODE_NUMBER;
    end else begin
      unique case (ch)
        sqllex_pkg::CH_QUOTE:  idle_mode = sqllex_pkg::MODE_STRING;
        sqllex_pkg::CH_BANG:   idle_mode = sqllex_pkg::MODE_BANG;
        sqllex_pkg::CH_GT:     idle_mode = sqllex_pkg::MODE_GT;
        sqllex_pkg::CH_LT:     idle_mode = sqllex_pkg::MODE_LT;
        sqllex_pkg::CH_STAR: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_STAR;
        end
        sqllex_pkg::CH_COMMA: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_COMMA;
        end
        sqllex_pkg::CH_SEMI: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_SEMI;
        end
        sqllex_pkg::CH_LPAREN: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_LPAREN;
        end
        sqllex_pkg::CH_RPAREN: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_RPAREN;
        end
        sqllex_pkg::CH_EQ: begin
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_EQ;
        end
        default: begin
          // Anything else, including every byte above 127, is a one-byte invalid token.
          idle_emit = 1'b1;
          idle_kind = sqllex_pkg::TK_INVALID;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // The pending token, as it would be emitted if it ended now.
  // ---------------------------------------------------------------------------
  logic [55:0]              kw_chars;
  logic [4:0]               ident_kind;
  logic                     flush_emit;
  logic [4:0]               flush_kind;
  logic [POSITION_BITS-1:0] flush_len;

  assign kw_chars = {kw_q[0], kw_q[1], kw_q[2], kw_q[3], kw_q[4], kw_q[5], kw_q[6]};
  // Identifiers longer than seven bytes never match a keyword.
  assign ident_kind = (len_q < KwSpan) ? sqllex_pkg::kw_lookup(kw_chars, len_q[2:0])
                                       : sqllex_pkg::TK_IDENT;

  always_comb begin
    flush_emit = 1'b1;
    flush_kind = sqllex_pkg::TK_INVALID;
    flush_len  = POSITION_BITS'(1);
    unique case (mode_q)
      sqllex_pkg::MODE_IDENT: begin
        flush_kind = ident_kind;
        flush_len  = len_q;
      end
      sqllex_pkg::MODE_NUMBER: begin
        flush_kind = sqllex_pkg::TK_NUMBER;
        flush_len  = len_q;
      end
      sqllex_pkg::MODE_STRING: begin
        flush_kind = sqllex_pkg::TK_STRING;
        flush_len  = len_q;
      end
      // A bang that is not followed by an equals sign is invalid.
      sqllex_pkg::MODE_BANG: flush_kind = sqllex_pkg::TK_INVALID;
      sqllex_pkg::MODE_GT:   flush_kind = sqllex_pkg::TK_GT;
      sqllex_pkg::MODE_LT:   flush_kind = sqllex_pkg::TK_LT;
      default:               flush_emit = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next mode.
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d = mode_q;
    if (accept) begin
      if (end_of_input_i) begin
        mode_d = sqllex_pkg::MODE_IDLE;
      end else if (restart) begin
        mode_d = idle_mode;
      end else begin
        unique case (mode_q)
          sqllex_pkg::MODE_STRING: begin
            if (is_quote) begin
              mode_d = sqllex_pkg::MODE_IDLE;
            end else if (is_nul) begin
              // An open string ends at a NUL, unterminated.
              mode_d = sqllex_pkg::MODE_STOP;
            end
          end
          sqllex_pkg::MODE_BANG, sqllex_pkg::MODE_GT, sqllex_pkg::MODE_LT: begin
            mode_d = sqllex_pkg::MODE_IDLE;
          end
          default: mode_d = mode_q;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Results of this transfer: up to two, the flushed token first.
  // ---------------------------------------------------------------------------
  logic                fa, fb;
  sqllex_pkg::result_t ra, rb;
  sqllex_pkg::result_t flush_res, idle_res;
  logic [4:0]          op_kind;
  sqllex_pkg::result_t slot0, slot1;
  logic [1:0]          n_res;

  assign flush_res = '{kind: flush_kind, start: to_field(start_q),
                       length: to_field(flush_len), last: 1'b0};
  assign idle_res  = '{kind: idle_kind, start: to_field(pos_q),
                       length: 16'd1, last: 1'b0};

  always_comb begin
    unique case (mode_q)
      sqllex_pkg::MODE_BANG: op_kind = sqllex_pkg::TK_NE;
      sqllex_pkg::MODE_GT:   op_kind = sqllex_pkg::TK_GE;
      default:               op_kind = sqllex_pkg::TK_LE;
    endcase
  end

  always_comb begin
    fa = 1'b0;
    fb = 1'b0;
    ra = flush_res;
    rb = idle_res;
    if (end_of_input_i) begin
      fa = flush_emit;
      fb = 1'b1;
      rb = '{kind: sqllex_pkg::TK_EOF, start: to_field(pos_q), length: 16'd0, last: 1'b0};
    end else if (restart) begin
      fa = flush_emit;
      fb = idle_emit;
    end else begin
      unique case (mode_q) inside
        sqllex_pkg::MODE_STRING: fa = is_quote || is_nul;
        sqllex_pkg::MODE_BANG, sqllex_pkg::MODE_GT, sqllex_pkg::MODE_LT: begin
          fa = 1'b1;
          ra = '{kind: op_kind, start: to_field(start_q), length: 16'd2, last: 1'b0};
        end
        default: fa = 1'b0;
      endcase
    end

    slot0 = fa ? ra : rb;
    slot1 = rb;
    n_res = {1'b0, fa} + {1'b0, fb};
    if (n_res == 2'd2) begin
      slot1.last = 1'b1;
    end else begin
      slot0.last = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Offset, token start, length and keyword bytes.
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    kw_d    = kw_q;
    if (accept) begin
      if (end_of_input_i) begin
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        for (int i = 0; i < sqllex_pkg::KW_DEPTH; i++) begin
          kw_d[i] = 8'h00;
        end
      end else if (mode_q != sqllex_pkg::MODE_STOP) begin
        pos_d = sat_inc(pos_q);
        if (restart) begin
          // String text starts after the opening quote.
          start_d = is_quote ? sat_inc(pos_q) : pos_q;
          len_d   = (is_alpha || is_digit) ? POSITION_BITS'(1) : '0;
          for (int i = 0; i < sqllex_pkg::KW_DEPTH; i++) begin
            kw_d[i] = 8'h00;
          end
          if (is_alpha) begin
            kw_d[0] = ch_upper;
          end
        end else if (mode_q == sqllex_pkg::MODE_IDENT) begin
          if (len_q < KwLimit) begin
            kw_d[len_q[2:0]] = ch_upper;
          end
          len_d = sat_inc(len_q);
        end else if ((mode_q == sqllex_pkg::MODE_NUMBER) ||
                     ((mode_q == sqllex_pkg::MODE_STRING) && !is_quote && !is_nul)) begin
          len_d = sat_inc(len_q);
        end
      end
    end
  end

  assign cnt_d = cnt_q + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sqllex_pkg::MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      for (int i = 0; i < sqllex_pkg::KW_DEPTH; i++) begin
        kw_q[i] <= 8'h00;
      end
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        wr_q <= wr_q + n_res;
      end
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  // Queue storage carries no reset; the count says which entries hold results.
  always_ff @(posedge clk_i) begin
    if (accept && (n_res != 2'd0)) begin
      fifo_q[wr_q] <= slot0;
    end
    if (accept && (n_res == 2'd2)) begin
      fifo_q[wr_q + 2'd1] <= slot1;
    end
  end

  assign token_kind_o  = fifo_q[rd_q].kind;
  assign text_start_o  = fifo_q[rd_q].start;
  assign text_length_o = fifo_q[rd_q].length;
  assign last_of_run_o = fifo_q[rd_q].last;

endmodule

FILE: src/sqllex_checker.sv
`include "sql_token_lexer_unit_assert.svh"

module sqllex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  token_kind_o,
  input logic [15:0] text_length_o,
  input logic        last_of_run_o
);

  // A held result stays offered.
  `SQLLEX_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // An empty result queue always leaves room for the next byte.
  `SQLLEX_ASSERT_NOW(a_empty_ready, !out_valid_o, !in_stall_o, "input stalled with empty queue")

  // The end token has no text and closes its run.
  `SQLLEX_ASSERT_NOW(a_eof_shape, out_valid_o && (token_kind_o == sqllex_pkg::TK_EOF), (text_length_o == 16'd0) && last_of_run_o, "malformed end token")

  // Two-byte comparison operators carry a length of two.
  `SQLLEX_ASSERT_NOW(a_op_len, out_valid_o && ((token_kind_o == sqllex_pkg::TK_NE) || (token_kind_o == sqllex_pkg::TK_GE) || (token_kind_o == sqllex_pkg::TK_LE)), text_length_o == 16'd2, "two-byte operator with wrong length")

endmodule

bind sql_token_lexer_unit sqllex_checker u_sqllex_checker (.*);

FILE: tb/sv/sql_token_lexer_unit_test.sv
module sql_token_lexer_unit_test;
  import sqllex_pkg::*;

  // Whitespace runs from horizontal tab up to carriage return, plus the space.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Bytes of random statements queued in each idling phase.
  localparam int unsigned PHASE_BYTES = 330;
  // An identifier this long runs well past the bytes kept for keyword matching.
  localparam int unsigned LONG_IDENT_BYTES = 20;
  // Idle cycles after the last token before the verdict.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } feed_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        in_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] text_start;
  logic [15:0] text_length;
  logic        last_of_run;

  // Percent of cycles on which the byte sender holds back, and on which the
  // token receiver stalls. The main sequence changes these between phases.
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 80;

  feed_item_t  byte_feed[$];
  result_t     pending_tokens[$];
  result_t     step_tokens[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_count = 0;

  string sql_keywords[KW_COUNT] = '{
    "SELECT", "FROM", "WHERE", "INSERT", "INTO",
    "VALUES", "CREATE", "TABLE", "INT", "VARCHAR"
  };

  // Shadow copy of the lexer state that the predictor below walks through.
  lex_mode_e   scan_mode;
  logic [15:0] next_offset;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [7:0]  tok_chars[KW_DEPTH];

  always #2 clk_i = ~clk_i;

  sql_token_lexer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (in_byte),
    .end_of_input_i (in_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .text_start_o   (text_start),
    .text_length_o  (text_length),
    .last_of_run_o  (last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Token predictor.
  // ---------------------------------------------------------------------------

  // Offsets and lengths stop at the top of their 16-bit range.
  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void reset_scanner();
    scan_mode   = MODE_IDLE;
    next_offset = '0;
    tok_start   = '0;
    tok_len     = '0;
    foreach (tok_chars[i]) tok_chars[i] = '0;
  endfunction

  function automatic void emit_token(logic [4:0] kind, logic [15:0] start,
                                     logic [15:0] length);
    result_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = length;
    tok.last   = 1'b0;
    step_tokens = {step_tokens, tok};
  endfunction

  // Only the first few identifier bytes are kept, upper-cased, for keyword matching.
  function automatic void keep_char(logic [7:0] b);
    if (tok_len < KW_DEPTH) begin
      tok_chars[tok_len[2:0]] = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    end
    tok_len = bump(tok_len);
  endfunction

  // An identifier is a keyword only when its length and every kept byte agree.
  function automatic logic [4:0] keyword_kind();
    bit same;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (tok_len == sql_keywords[k].len()) begin
        same = 1'b1;
        for (int i = 0; i < sql_keywords[k].len(); i++) begin
          if (tok_chars[i] != sql_keywords[k][i]) same = 1'b0;
        end
        if (same) return 5'(TK_SELECT + k);
      end
    end
    return TK_IDENT;
  endfunction

  // Emits whatever token is open and returns to idle, unless lexing has stopped.
  function automatic void finish_token();
    case (scan_mode)
      MODE_IDENT:  emit_token(keyword_kind(), tok_start, tok_len);
      MODE_NUMBER: emit_token(TK_NUMBER, tok_start, tok_len);
      MODE_STRING: emit_token(TK_STRING, tok_start, tok_len);
      MODE_BANG:   emit_token(TK_INVALID, tok_start, 16'd1);
      MODE_GT:     emit_token(TK_GT, tok_start, 16'd1);
      MODE_LT:     emit_token(TK_LT, tok_start, 16'd1);
      default: ;
    endcase
    if (scan_mode != MODE_STOP) scan_mode = MODE_IDLE;
  endfunction

  // Lexes one byte as the first byte of a token.
  function automatic void start_token(logic [7:0] b);
    tok_start = next_offset;
    tok_len   = '0;
    foreach (tok_chars[i]) tok_chars[i] = '0;
    if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
      // Whitespace between tokens is dropped.
    end else if (b == CH_NUL) begin
      scan_mode = MODE_STOP;
    end else if (is_letter(b)) begin
      scan_mode = MODE_IDENT;
      keep_char(b);
    end else if (is_digit(b)) begin
      scan_mode = MODE_NUMBER;
      tok_len   = 16'd1;
    end else begin
      case (b)
        CH_QUOTE: begin
          scan_mode = MODE_STRING;
          tok_start = bump(next_offset);
        end
        CH_BANG:   scan_mode = MODE_BANG;
        CH_GT:     scan_mode = MODE_GT;
        CH_LT:     scan_mode = MODE_LT;
        CH_STAR:   emit_token(TK_STAR, next_offset, 16'd1);
        CH_COMMA:  emit_token(TK_COMMA, next_offset, 16'd1);
        CH_SEMI:   emit_token(TK_SEMI, next_offset, 16'd1);
        CH_LPAREN: emit_token(TK_LPAREN, next_offset, 16'd1);
        CH_RPAREN: emit_token(TK_RPAREN, next_offset, 16'd1);
        CH_EQ:     emit_token(TK_EQ, next_offset, 16'd1);
        default:   emit_token(TK_INVALID, next_offset, 16'd1);
      endcase
    end
  endfunction

  // Works out the tokens that one accepted byte transfer causes and queues them
  // in order, with the last one of the step flagged.
  function automatic void lex_byte(logic [7:0] b, logic eoi);
    logic [4:0] pair_kind;
    step_tokens.delete();
    if (eoi) begin
      finish_token();
      emit_token(TK_EOF, next_offset, '0);
      reset_scanner();
    end else if (scan_mode != MODE_STOP) begin
      case (scan_mode)
        MODE_IDENT: begin
          if (is_letter(b) || is_digit(b) || b == CH_US) begin
            keep_char(b);
          end else begin
            finish_token();
            start_token(b);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b)) begin
            tok_len = bump(tok_len);
          end else begin
            finish_token();
            start_token(b);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            finish_token();
          end else if (b == CH_NUL) begin
            finish_token();
            scan_mode = MODE_STOP;
          end else begin
            tok_len = bump(tok_len);
          end
        end
        MODE_BANG, MODE_GT, MODE_LT: begin
          if (b == CH_EQ) begin
            pair_kind = (scan_mode == MODE_BANG) ? TK_NE :
                        (scan_mode == MODE_GT) ? TK_GE : TK_LE;
            emit_token(pair_kind, tok_start, 16'd2);
            scan_mode = MODE_IDLE;
          end else begin
            finish_token();
            start_token(b);
          end
        end
        default: start_token(b);
      endcase
      next_offset = bump(next_offset);
    end
    if (step_tokens.size() != 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
      pending_tokens = {pending_tokens, step_tokens};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Statement generation.
  // ---------------------------------------------------------------------------

  function automatic void feed_byte(logic [7:0] b);
    feed_item_t item;
    item.data = b;
    item.eoi  = 1'b0;
    byte_feed = {byte_feed, item};
    bytes_queued++;
  endfunction

  // The data byte of the end transfer is ignored by the block, so it is random.
  function automatic void feed_end();
    feed_item_t item;
    item.data = 8'($urandom_range(255));
    item.eoi  = 1'b1;
    byte_feed = {byte_feed, item};
    bytes_queued++;
  endfunction

  function automatic void feed_text(string s);
    foreach (s[i]) feed_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_blank();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(CH_TAB, CH_CR)) : CH_SPACE;
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(3))
      0:       return 8'("A" + $urandom_range(25));
      1:       return 8'("a" + $urandom_range(25));
      2:       return 8'("0" + $urandom_range(9));
      default: return CH_US;
    endcase
  endfunction

  // Any byte that may sit inside a quoted string without closing or cutting it.
  function automatic logic [7:0] random_string_char();
    logic [7:0] b;
    do b = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255))
                                    : 8'($urandom_range(32, 126));
    while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic string mixed_case(string s);
    string r;
    r = s;
    foreach (r[i]) begin
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(1)) r[i] = r[i] + 8'd32;
    end
    return r;
  endfunction

  function automatic void queue_token();
    string punct;
    string compare_ops[5];
    string strays;
    punct       = "*,;()=";
    compare_ops = '{"!=", ">=", "<=", ">", "<"};
    strays      = "#$%&+-./:?@[\\]^{|}~\"_";
    case ($urandom_range(19))
      0, 1, 2, 3: begin
        // Keywords in any case; now and then a suffix turns them into plain
        // identifiers, including ones past the kept prefix.
        feed_text(mixed_case(sql_keywords[$urandom_range(KW_COUNT - 1)]));
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) feed_byte(random_word_char());
        end
      end
      4, 5, 6: begin
        feed_byte(($urandom_range(1)) ? 8'("a" + $urandom_range(25))
                                      : 8'("A" + $urandom_range(25)));
        repeat ($urandom_range(0, 10)) feed_byte(random_word_char());
      end
      7, 8: repeat ($urandom_range(1, 6)) feed_byte(8'("0" + $urandom_range(9)));
      9, 10: begin
        feed_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) feed_byte(random_string_char());
        feed_byte(CH_QUOTE);
      end
      11, 12, 13: feed_byte(punct[$urandom_range(punct.len() - 1)]);
      14, 15: feed_text(compare_ops[$urandom_range(4)]);
      16: begin
        if ($urandom_range(1)) feed_byte(8'($urandom_range(128, 255)));
        else feed_byte(strays[$urandom_range(strays.len() - 1)]);
      end
      17: feed_byte(CH_BANG);
      18: begin
        // Raw noise; a NUL among it cuts the rest of the statement off.
        if ($urandom_range(3) == 0) feed_byte(CH_NUL);
        else feed_byte(8'($urandom_range(255)));
      end
      default: repeat ($urandom_range(1, 4)) feed_byte(random_blank());
    endcase
  endfunction

  // A statement is a run of tokens, mostly separated by whitespace. Tokens that
  // touch make one byte close a token and produce another in the same step.
  function automatic void queue_statement();
    if ($urandom_range(19) == 0) begin
      feed_end();
      return;
    end
    if ($urandom_range(2) == 0) feed_byte(random_blank());
    repeat ($urandom_range(1, 14)) begin
      queue_token();
      if ($urandom_range(9) < 7) begin
        repeat ($urandom_range(1, 3)) feed_byte(random_blank());
      end
    end
    // Sometimes the statement ends inside an open string.
    if ($urandom_range(9) == 0) begin
      feed_byte(CH_QUOTE);
      repeat ($urandom_range(0, 4)) feed_byte(random_string_char());
    end
    feed_end();
  endfunction

  function automatic void queue_statements(int unsigned budget);
    int unsigned mark;
    mark = bytes_queued;
    while (bytes_queued - mark < budget) queue_statement();
  endfunction

  // Checked at the falling edge, where every transfer of the rising edge is done.
  task automatic wait_for_drain();
    while (byte_feed.size() != 0 || in_valid || pending_tokens.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. A transfer completes at a rising edge where valid is high and
  // the block does not stall; the predictor then sees the byte, and the next
  // byte of the feed is offered unless the sender chooses to idle this cycle.
  // A stalled byte is held unchanged.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit         accepted;
    feed_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      reset_scanner();
    end else begin
      accepted = in_valid && !in_stall;
      if (accepted) lex_byte(in_byte, in_end);
      if (!in_valid || accepted) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_feed.pop_front();
          in_byte  <= nxt.data;
          in_end   <= nxt.eoi;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token monitor. Every token transfer is matched against the oldest token
  // still expected, field by field. The stall toward the block is redrawn each
  // cycle, so it can land on any phase of the block's work.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch($sformatf("token kind %0d start %0d length %0d with none expected",
                                    token_kind, text_start, text_length));
        end else begin
          want = pending_tokens.pop_front();
          if (token_kind !== want.kind)
            report_mismatch($sformatf("token_kind %0d, expected %0d", token_kind, want.kind));
          if (text_start !== want.start)
            report_mismatch($sformatf("text_start %0d, expected %0d (kind %0d)",
                                      text_start, want.start, want.kind));
          if (text_length !== want.length)
            report_mismatch($sformatf("text_length %0d, expected %0d (kind %0d)",
                                      text_length, want.length, want.kind));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                      last_of_run, want.last, want.kind));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed statements. The first walks every punctuation byte, both forms
    // of each comparison, a lone bang, a high byte that closes an identifier
    // and is itself invalid, and a string cut off by a NUL after which a byte
    // is ignored.
    feed_text("sElect*,;()=");
    feed_text("!=<=>=!<>a");
    feed_byte(8'hFF);
    feed_text("'x");
    feed_byte(CH_NUL);
    feed_byte("q");
    feed_end();
    // A seven-byte keyword, the same word one byte longer, a number, and a
    // string still open when the statement ends.
    feed_text("VARCHAR\tvarchars 09'u");
    feed_end();

    // First the sender idles rarely while the receiver stalls most of the time.
    queue_statements(PHASE_BYTES);
    wait_for_drain();

    // The sender holds off until every token has come, then the roles swap.
    send_idle_pct = 80;
    recv_idle_pct = 7;
    queue_statements(PHASE_BYTES);
    wait_for_drain();

    // Neither side idles. The last statement holds an identifier that runs
    // well past the kept prefix, closed directly by the tokens that follow.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_statements(PHASE_BYTES);
    feed_text("x ");
    repeat (LONG_IDENT_BYTES) feed_byte("b");
    feed_text(")'s' 42 <");
    feed_end();
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sql_token_lexer_unit.f
+incdir+src
src/sqllex_pkg.sv
src/sql_token_lexer_unit.sv
src/sqllex_checker.sv
tb/sv/sql_token_lexer_unit_test.sv
